// File: src/hct_pkg.sv
// Shared types, constants and helper function of the handheld console timer.
package hct_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	localparam logic [15:0] ADDR_DIV = 16'hff04;
	localparam logic [15:0] ADDR_CNT = 16'hff05;
	localparam logic [15:0] ADDR_MOD = 16'hff06;
	localparam logic [15:0] ADDR_CTL = 16'hff07;

	localparam logic [7:0]  CTL_READ_ONES = 8'hf8;
	localparam logic [7:0]  UNMAPPED_DATA = 8'hff;
	localparam logic [15:0] DIV_STEP      = 16'h0004;
	localparam int unsigned AUDIO_BIT     = 12;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] bus_addr;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
		logic       audio_div_event;
	} rsp_t;

	// control: bit 2 enable, bits 1..0 mode
	function automatic logic timer_sig(input logic [2:0] ctl, input logic [15:0] div);
		logic sel;
		case (ctl[1:0])
			2'd0:    sel = div[9];
			2'd1:    sel = div[3];
			2'd2:    sel = div[5];
			2'd3:    sel = div[7];
			default: sel = 1'b0;
		endcase
		return ctl[2] & sel;
	endfunction

endpackage

// File: src/hct_req_if.sv
// Request channel: transaction type, bus address and write byte.
interface hct_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] bus_addr;
	logic [7:0]  write_data;

	modport source (output valid, req_type, bus_addr, write_data, input ready);
	modport sink   (input valid, req_type, bus_addr, write_data, output ready);
endinterface

// File: src/hct_rsp_if.sv
// Response channel: read byte, interrupt and audio divider event.
interface hct_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       timer_irq;
	logic       audio_div_event;

	modport source (output valid, read_data, timer_irq, audio_div_event, input ready);
	modport sink   (input valid, read_data, timer_irq, audio_div_event, output ready);
endinterface

// File: src/hct_in_reg.sv
// Input register stage of the timer: captures one request transaction.
module hct_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	hct_req_if.sink       req,
	input  logic          adv,
	output logic          valid_s1,
	output hct_pkg::req_t req_s1
);

	logic take;

	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.req_type   <= req.req_type;
			req_s1.bus_addr   <= req.bus_addr;
			req_s1.write_data <= req.write_data;
		end
	end

endmodule

// File: src/hct_exec.sv
// Timer state registers and the single-pass update for one request.
module hct_exec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  hct_pkg::req_t req_s1,
	output hct_pkg::rsp_t rsp_d
);

	logic [15:0] div_q,  div_n;
	logic [7:0]  cnt_q,  cnt_n;
	logic [7:0]  mod_q,  mod_n;
	logic [2:0]  ctl_q,  ctl_n;
	logic        pend_q, pend_n;
	logic        rjd_q,  rjd_n;

	always_comb begin
		logic        do_div;
		logic [15:0] div_new;
		logic [2:0]  nc;
		div_n   = div_q;
		cnt_n   = cnt_q;
		mod_n   = mod_q;
		ctl_n   = ctl_q;
		pend_n  = pend_q;
		rjd_n   = rjd_q;
		rsp_d   = '0;
		do_div  = 1'b0;
		div_new = div_q + hct_pkg::DIV_STEP;
		nc      = req_s1.write_data[2:0];

		case (req_s1.req_type)
			hct_pkg::REQ_TICK: begin
				do_div = 1'b1;
			end
			hct_pkg::REQ_READ: begin
				case (req_s1.bus_addr)
					hct_pkg::ADDR_DIV: rsp_d.read_data = div_q[15:8];
					hct_pkg::ADDR_CNT: rsp_d.read_data = pend_q ? 8'h00 : cnt_q;
					hct_pkg::ADDR_MOD: rsp_d.read_data = mod_q;
					hct_pkg::ADDR_CTL: rsp_d.read_data = {5'b0, ctl_q} | hct_pkg::CTL_READ_ONES;
					default:           rsp_d.read_data = hct_pkg::UNMAPPED_DATA;
				endcase
			end
			hct_pkg::REQ_WRITE: begin
				case (req_s1.bus_addr)
					hct_pkg::ADDR_DIV: begin
						do_div  = 1'b1;
						div_new = '0;
					end
					hct_pkg::ADDR_CNT: begin
						// drop the write while the reload tick is still visible
						if (!rjd_q) begin
							cnt_n  = req_s1.write_data;
							pend_n = 1'b0;
						end
					end
					hct_pkg::ADDR_MOD: begin
						mod_n = req_s1.write_data;
						if (rjd_q) begin
							cnt_n = req_s1.write_data;
						end
					end
					hct_pkg::ADDR_CTL: begin
						ctl_n = nc;
						if (hct_pkg::timer_sig(ctl_q, div_q) && !hct_pkg::timer_sig(nc, div_q)) begin
							cnt_n = cnt_q + 8'd1;
							if (cnt_n == 8'd0) begin
								pend_n = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (do_div) begin
			div_n = div_new;
			rjd_n = 1'b0;
			if (pend_q) begin
				pend_n          = 1'b0;
				cnt_n           = mod_q;
				rjd_n           = 1'b1;
				rsp_d.timer_irq = 1'b1;
			end
			if (hct_pkg::timer_sig(ctl_q, div_q) && !hct_pkg::timer_sig(ctl_q, div_new)) begin
				cnt_n = cnt_n + 8'd1;
				if (cnt_n == 8'd0) begin
					pend_n = 1'b1;
				end
			end
			rsp_d.audio_div_event = div_q[hct_pkg::AUDIO_BIT] && !div_new[hct_pkg::AUDIO_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= '0;
			cnt_q  <= '0;
			mod_q  <= '0;
			ctl_q  <= '0;
			pend_q <= 1'b0;
			rjd_q  <= 1'b0;
		end else if (adv) begin
			div_q  <= div_n;
			cnt_q  <= cnt_n;
			mod_q  <= mod_n;
			ctl_q  <= ctl_n;
			pend_q <= pend_n;
			rjd_q  <= rjd_n;
		end
	end

endmodule

// File: src/hct_out_reg.sv
// Result register of the timer: holds one response transaction until taken.
module hct_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  hct_pkg::rsp_t rsp_d,
	output logic          free,
	hct_rsp_if.source     rsp
);

	logic          valid_q;
	hct_pkg::rsp_t rsp_q;

	assign free                = !valid_q || rsp.ready;
	assign rsp.valid           = valid_q;
	assign rsp.read_data       = rsp_q.read_data;
	assign rsp.timer_irq       = rsp_q.timer_irq;
	assign rsp.audio_div_event = rsp_q.audio_div_event;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// File: src/handheld_console_timer_core.sv
// Divider and programmable counter timer, one request per cycle while responses are taken.
// Order: a request is held in the input register, then its response in the result register.
// Throughput: one request per cycle unless the response stalls; the state update for a request
// is one pass between the input register and the result register.
// Reset: asynchronous, active low; clears divider, counter, modulo, control,
// reload flags and both stage valids.
module handheld_console_timer_core (
	input  logic      clk,
	input  logic      arst_n,
	hct_req_if.sink   req,
	hct_rsp_if.source rsp
);

	logic          valid_s1;
	hct_pkg::req_t req_s1;
	hct_pkg::rsp_t rsp_d;
	logic          free;
	logic          adv;

	// advance the held request when the result register can take it
	assign adv = valid_s1 && free;

	hct_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	hct_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req_s1 (req_s1),
		.rsp_d  (rsp_d)
	);

	hct_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.rsp_d  (rsp_d),
		.free   (free),
		.rsp    (rsp)
	);

endmodule

// File: src/hct_checker.sv
// Port-level checks of the timer core and their attachment to it.
module hct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic       rsp_timer_irq,
	input logic       rsp_audio_div_event
);

	// a stalled response keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
			&& $stable(rsp_timer_irq) && $stable(rsp_audio_div_event))
		else $error("stalled response changed");

	// interrupts come only from divider updates, which read nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_timer_irq |-> rsp_read_data == 8'h00)
		else $error("interrupt on a read transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_audio_div_event |-> rsp_read_data == 8'h00)
		else $error("audio event on a read transaction");

endmodule

bind handheld_console_timer_core hct_checker u_hct_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_read_data       (rsp.read_data),
	.rsp_timer_irq       (rsp.timer_irq),
	.rsp_audio_div_event (rsp.audio_div_event)
);
